// File: rtl/core/dmip_pkg.sv
// Shared types and constants of the dual motor incremental PID unit.
// Has no dependencies; every other file of the unit imports it.
package dmip_pkg;

   // Field widths.
   localparam int OPCODE_W   = 2;
   localparam int DELTA_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 8;
   localparam int PWM_W      = 9;
   localparam int ACC_W      = 24;
   localparam int ERR_W      = 32;
   localparam int SPD_ERR_W  = 17;
   localparam int TICK_CNT_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Result queue geometry.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = 3;
   localparam int RSP_CNT_W = 4;

   // Opcodes of the request word.
   localparam logic [OPCODE_W-1:0] OP_TICK       = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TOGGLE     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SET_TARGET = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KI  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_KP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_KI    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_KD    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT = 3'd6;

   // Configuration reset values.
   localparam logic [GAIN_W-1:0]  RST_SPEED_KP  = 16'd205;
   localparam logic [GAIN_W-1:0]  RST_SPEED_KI  = 16'd614;
   localparam logic [GAIN_W-1:0]  RST_SPEED_KD  = 16'd0;
   localparam logic [GAIN_W-1:0]  RST_POS_KP    = 16'd2048;
   localparam logic [GAIN_W-1:0]  RST_POS_KI    = 16'd41;
   localparam logic [GAIN_W-1:0]  RST_POS_KD    = 16'd41;
   localparam logic [LIMIT_W-1:0] RST_OUT_LIMIT = 8'd100;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gain_set_type;

   // Command from the front end to one lane.
   typedef struct packed {
      logic                    step;
      logic                    clear;
      logic signed [ERR_W-1:0] err;
   } lane_cmd_type;

   // What a lane hands to the merging stage.
   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] acc;
   } lane_result_type;

   typedef struct packed {
      logic signed [PWM_W-1:0] pwm1;
      logic signed [PWM_W-1:0] pwm2;
      logic                    position_mode;
   } rsp_word_type;

endpackage

// File: rtl/core/dmip_ifs.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on dmip_pkg for the field widths.
interface dmip_req_if;
   import dmip_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic signed [DELTA_W-1:0] enc1_delta;
   logic signed [DELTA_W-1:0] enc2_delta;
   logic signed [DELTA_W-1:0] target_speed;

   modport source (output valid, output opcode, output enc1_delta, output enc2_delta,
                   output target_speed, input ready);
   modport sink   (input valid, input opcode, input enc1_delta, input enc2_delta,
                   input target_speed, output ready);
endinterface

interface dmip_rsp_if;
   import dmip_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [PWM_W-1:0] pwm1;
   logic signed [PWM_W-1:0] pwm2;
   logic                    position_mode;

   modport source (output valid, output pwm1, output pwm2, output position_mode,
                   input ready);
   modport sink   (input valid, input pwm1, input pwm2, input position_mode,
                   output ready);
endinterface

// File: rtl/core/dmip_front.sv
// Front end: decodes request words, keeps tick, mode, setpoint and position
// difference state, and issues one command per lane. Depends on dmip_pkg, dmip_ifs.
module dmip_front #(
   parameter int TICK_DIVIDE = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   dmip_req_if.sink              req,
   input  logic                  credit_ok,
   output logic                  reserve,
   output dmip_pkg::lane_cmd_type speed_cmd,
   output dmip_pkg::lane_cmd_type follow_cmd
);
   import dmip_pkg::*;

   logic [TICK_CNT_W-1:0]   tick_count_ff, tick_count_in, tick_next;
   logic                    mode_ff, mode_in;
   logic signed [DELTA_W-1:0] setpoint_ff, setpoint_in;
   logic signed [ERR_W-1:0] pos_diff_ff, pos_diff_in;
   lane_cmd_type            speed_cmd_ff, speed_cmd_in;
   lane_cmd_type            follow_cmd_ff, follow_cmd_in;
   logic                    accept, is_tick, is_toggle, step;
   logic signed [SPD_ERR_W-1:0] speed_err;

   assign req.ready  = credit_ok;
   assign accept     = req.valid & req.ready;
   assign is_tick    = accept & (req.opcode == OP_TICK);
   assign is_toggle  = accept & (req.opcode == OP_TOGGLE);
   assign tick_next  = tick_count_ff + TICK_CNT_W'(1);
   assign step       = is_tick & (tick_next >= TICK_CNT_W'(TICK_DIVIDE));
   assign reserve    = step;
   assign speed_err  = SPD_ERR_W'(setpoint_ff) - SPD_ERR_W'(req.enc1_delta);

   always_comb begin
      tick_count_in = tick_count_ff;
      if (is_tick) begin
         tick_count_in = step ? '0 : tick_next;
      end
      mode_in     = mode_ff ^ is_toggle;
      setpoint_in = (accept && req.opcode == OP_SET_TARGET) ? req.target_speed : setpoint_ff;
      // The wrapped difference of the two position counters is all the loops use,
      // so it is kept directly.
      pos_diff_in = pos_diff_ff;
      if (step) begin
         pos_diff_in = pos_diff_ff + ERR_W'(req.enc1_delta) - ERR_W'(req.enc2_delta);
      end

      speed_cmd_in.step   = step & ~mode_ff;
      speed_cmd_in.clear  = is_toggle & mode_ff;
      speed_cmd_in.err    = ERR_W'(speed_err);
      follow_cmd_in.step  = step & mode_ff;
      follow_cmd_in.clear = is_toggle & ~mode_ff;
      follow_cmd_in.err   = pos_diff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         mode_ff       <= 1'b0;
         setpoint_ff   <= '0;
         pos_diff_ff   <= '0;
         speed_cmd_ff  <= '0;
         follow_cmd_ff <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         mode_ff       <= mode_in;
         setpoint_ff   <= setpoint_in;
         pos_diff_ff   <= pos_diff_in;
         speed_cmd_ff  <= speed_cmd_in;
         follow_cmd_ff <= follow_cmd_in;
      end
   end

   assign speed_cmd  = speed_cmd_ff;
   assign follow_cmd = follow_cmd_ff;

endmodule

// File: rtl/core/dmip_lane.sv
// One incremental PID lane: error history, difference terms, gain multiplies,
// increment sum and the clamped output accumulator. Depends on dmip_pkg.
module dmip_lane #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dmip_pkg::lane_cmd_type        cmd,
   input  dmip_pkg::gain_set_type        gains,
   input  logic [dmip_pkg::LIMIT_W-1:0]  limit,
   output dmip_pkg::lane_result_type     result
);
   import dmip_pkg::*;

   localparam int PDIFF_W = ERR_W + 1;
   localparam int DDIFF_W = ERR_W + 2;
   localparam int PP_W    = GAIN_W + 1 + PDIFF_W;
   localparam int PI_W    = GAIN_W + 1 + ERR_W;
   localparam int PD_W    = GAIN_W + 1 + DDIFF_W;
   localparam int INC_W   = PD_W + 2;
   localparam int SUM_W   = INC_W + 1;

   // Stage 1: error history, newest first.
   logic signed [ERR_W-1:0]   e0_ff, e1_ff, e2_ff;
   logic                      v1_ff, c1_ff;
   // Stage 2: difference terms.
   logic signed [PDIFF_W-1:0] pdiff_ff, pdiff_in;
   logic signed [DDIFF_W-1:0] ddiff_ff, ddiff_in;
   logic signed [ERR_W-1:0]   err_ff;
   logic                      v2_ff, c2_ff;
   // Stage 3: products.
   logic signed [GAIN_W:0]    kp_s, ki_s, kd_s;
   logic signed [PP_W-1:0]    pp_ff, pp_in;
   logic signed [PI_W-1:0]    pi_ff, pi_in;
   logic signed [PD_W-1:0]    pd_ff, pd_in;
   logic                      v3_ff, c3_ff;
   // Stage 4: increment.
   logic signed [INC_W-1:0]   inc_ff, inc_in;
   logic                      v4_ff, c4_ff;
   // Stage 5: accumulator.
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      done_ff;
   logic signed [SUM_W-1:0]   sum, lim, clamped;

   assign kp_s = {1'b0, gains.kp};
   assign ki_s = {1'b0, gains.ki};
   assign kd_s = {1'b0, gains.kd};

   assign pdiff_in = PDIFF_W'(e0_ff) - PDIFF_W'(e1_ff);
   assign ddiff_in = DDIFF_W'(e0_ff) - (DDIFF_W'(e1_ff) <<< 1) + DDIFF_W'(e2_ff);

   assign pp_in = kp_s * pdiff_ff;
   assign pi_in = ki_s * err_ff;
   assign pd_in = kd_s * ddiff_ff;

   assign inc_in = INC_W'(pp_ff) + INC_W'(pi_ff) + INC_W'(pd_ff);

   always_comb begin
      sum = SUM_W'(acc_ff) + SUM_W'(inc_ff);
      lim = SUM_W'(limit) <<< GAIN_FRAC_BITS;
      if (sum > lim) begin
         clamped = lim;
      end else if (sum < -lim) begin
         clamped = -lim;
      end else begin
         clamped = sum;
      end
      acc_in = acc_ff;
      if (c4_ff) begin
         acc_in = '0;
      end else if (v4_ff) begin
         acc_in = clamped[ACC_W-1:0];
      end
   end

   // Control and loop state.
   always_ff @(posedge clock) begin
      if (reset) begin
         e0_ff   <= '0;
         e1_ff   <= '0;
         e2_ff   <= '0;
         acc_ff  <= '0;
         v1_ff   <= 1'b0;
         c1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         c2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         c3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         c4_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            e0_ff <= '0;
            e1_ff <= '0;
            e2_ff <= '0;
         end else if (cmd.step) begin
            e0_ff <= cmd.err;
            e1_ff <= e0_ff;
            e2_ff <= e1_ff;
         end
         acc_ff  <= acc_in;
         v1_ff   <= cmd.step;
         c1_ff   <= cmd.clear;
         v2_ff   <= v1_ff;
         c2_ff   <= c1_ff;
         v3_ff   <= v2_ff;
         c3_ff   <= c2_ff;
         v4_ff   <= v3_ff;
         c4_ff   <= c3_ff;
         done_ff <= v4_ff;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      pdiff_ff <= pdiff_in;
      ddiff_ff <= ddiff_in;
      err_ff   <= e0_ff;
      pp_ff    <= pp_in;
      pi_ff    <= pi_in;
      pd_ff    <= pd_in;
      inc_ff   <= inc_in;
   end

   assign result.done = done_ff;
   assign result.acc  = acc_ff;

`ifndef NO_ASSERTIONS
   a_acc_cleared : assert property (@(posedge clock) c4_ff |=> acc_ff == '0)
      else $error("accumulator not cleared by a mode entry");
   a_hist_cleared : assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (e0_ff == '0 && e1_ff == '0 && e2_ff == '0))
      else $error("error history not cleared by a mode entry");
   a_step_clear_apart : assert property (@(posedge clock) disable iff (reset)
      !(v4_ff && c4_ff))
      else $error("step and clear met in the same stage");
`endif

endmodule

// File: rtl/core/dmip_merge.sv
// Merging stage: combines the two lane results into one result word and
// queues it for the result channel. Depends on dmip_pkg, dmip_ifs.
module dmip_merge #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dmip_pkg::lane_result_type speed_res,
   input  dmip_pkg::lane_result_type follow_res,
   input  logic                      reserve,
   output logic                      credit_ok,
   dmip_rsp_if.source                rsp
);
   import dmip_pkg::*;

   rsp_word_type           queue_ff [RSP_DEPTH];
   rsp_word_type           word_in, head;
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]   count_ff, count_in, reserved_ff, reserved_in;
   logic                   wr, rd;
   logic signed [PWM_W-1:0] speed_pwm, follow_pwm;

   // Clamped accumulator truncated toward zero to a whole PWM value.
   function automatic logic signed [PWM_W-1:0] to_pwm(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] whole;
      mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      whole = mag >> GAIN_FRAC_BITS;
      return acc[ACC_W-1] ? PWM_W'(-whole) : PWM_W'(whole);
   endfunction

   assign speed_pwm  = to_pwm(speed_res.acc);
   assign follow_pwm = to_pwm(follow_res.acc);

   // Motor 1's position loop always sees zero error from a cleared state,
   // so its drive in position mode is zero.
   always_comb begin
      word_in.position_mode = follow_res.done;
      word_in.pwm1          = follow_res.done ? '0 : speed_pwm;
      word_in.pwm2          = follow_res.done ? follow_pwm : speed_pwm;
   end

   assign wr          = speed_res.done | follow_res.done;
   assign rd          = rsp.valid & rsp.ready;
   assign count_in    = count_ff + RSP_CNT_W'(wr) - RSP_CNT_W'(rd);
   assign reserved_in = reserved_ff + RSP_CNT_W'(reserve) - RSP_CNT_W'(rd);
   assign credit_ok   = reserved_ff < RSP_CNT_W'(RSP_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         reserved_ff <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (rd) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         count_ff    <= count_in;
         reserved_ff <= reserved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         queue_ff[wr_ptr_ff] <= word_in;
      end
   end

   assign head              = queue_ff[rd_ptr_ff];
   assign rsp.valid         = count_ff != '0;
   assign rsp.pwm1          = head.pwm1;
   assign rsp.pwm2          = head.pwm2;
   assign rsp.position_mode = head.position_mode;

`ifndef NO_ASSERTIONS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(wr && !rd && count_ff == RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue written while full");
   a_reserved_covers : assert property (@(posedge clock) disable iff (reset)
      count_ff <= reserved_ff)
      else $error("queued words exceed reserved slots");
   a_reserved_bound : assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("more slots reserved than the queue holds");
`endif

endmodule

// File: rtl/core/dual_motor_incremental_pid_unit.sv
// Top level of the dual motor incremental PID unit: configuration registers,
// front end, two PID lanes and the merging stage. Depends on dmip_pkg, dmip_ifs.
//
//   Channel  Direction  Handshake          Word
//   req_bus  in         valid/ready        opcode, enc1_delta, enc2_delta, target_speed
//   rsp_bus  out        valid/ready        pwm1, pwm2, position_mode
//   csr_*    in         csr_we, no wait    csr_index, csr_wdata
//
// One request word is taken every cycle while the result queue has room.
// A control step's result word passes the front end registers, loaded at the edge
// that takes its request word, then the history, difference, multiply, sum and
// accumulate stages and the queue write before it is valid on rsp_bus.
// The eight-entry result queue reserves a slot for every control step in flight, so
// req_bus.ready drops only when eight results are pending and the consumer stalls.
// Reset is synchronous and clears all loop state, counters and the configuration
// registers to their default gains and limit.
module dual_motor_incremental_pid_unit #(
   parameter int TICK_DIVIDE    = 10,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   dmip_req_if.sink                            req_bus,
   dmip_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [dmip_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmip_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dmip_pkg::*;

   gain_set_type          speed_gain_ff, pos_gain_ff;
   logic [LIMIT_W-1:0]    out_limit_ff;
   lane_cmd_type          speed_cmd, follow_cmd;
   lane_result_type       speed_res, follow_res;
   logic                  credit_ok, reserve;

   // Configuration registers. Writes must arrive only while the unit is idle; the
   // block itself does not enforce this. An index past the last register is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_ff.kp <= RST_SPEED_KP;
         speed_gain_ff.ki <= RST_SPEED_KI;
         speed_gain_ff.kd <= RST_SPEED_KD;
         pos_gain_ff.kp   <= RST_POS_KP;
         pos_gain_ff.ki   <= RST_POS_KI;
         pos_gain_ff.kd   <= RST_POS_KD;
         out_limit_ff     <= RST_OUT_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED_KP:  speed_gain_ff.kp <= csr_wdata;
            CSR_SPEED_KI:  speed_gain_ff.ki <= csr_wdata;
            CSR_SPEED_KD:  speed_gain_ff.kd <= csr_wdata;
            CSR_POS_KP:    pos_gain_ff.kp   <= csr_wdata;
            CSR_POS_KI:    pos_gain_ff.ki   <= csr_wdata;
            CSR_POS_KD:    pos_gain_ff.kd   <= csr_wdata;
            CSR_OUT_LIMIT: out_limit_ff     <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The front end decides which lane steps: the speed lane in speed mode,
   // the follow lane (motor 2 chasing motor 1's position) in position mode.
   dmip_front #(
      .TICK_DIVIDE (TICK_DIVIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .credit_ok  (credit_ok),
      .reserve    (reserve),
      .speed_cmd  (speed_cmd),
      .follow_cmd (follow_cmd)
   );

   dmip_lane #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_speed_lane (
      .clock  (clock),
      .reset  (reset),
      .cmd    (speed_cmd),
      .gains  (speed_gain_ff),
      .limit  (out_limit_ff),
      .result (speed_res)
   );

   dmip_lane #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_follow_lane (
      .clock  (clock),
      .reset  (reset),
      .cmd    (follow_cmd),
      .gains  (pos_gain_ff),
      .limit  (out_limit_ff),
      .result (follow_res)
   );

   // Both lanes have the same depth, so results leave in request order.
   dmip_merge #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .speed_res  (speed_res),
      .follow_res (follow_res),
      .reserve    (reserve),
      .credit_ok  (credit_ok),
      .rsp        (rsp_bus)
   );

endmodule

// File: dv/pid_step_checker.sv
`timescale 1ns / 1ps
// Checker of the dual motor PID unit: follows accepted request words and register
// writes, predicts every result word and compares the results in order of arrival.
// Depends on dmip_pkg and the channel interfaces in dmip_ifs.
module pid_step_checker #(
   parameter int TICK_DIVIDE    = 10,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   dmip_req_if                             req_bus,
   dmip_rsp_if                             rsp_bus,
   input  logic                            csr_we,
   input  logic [dmip_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dmip_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              error_count,
   output int                              results_due
);
   import dmip_pkg::*;

   // Later mismatches are still counted, only their reports are dropped.
   localparam int REPORT_CAP = 100;

   logic [GAIN_W-1:0]           spd_kp, spd_ki, spd_kd;
   logic [GAIN_W-1:0]           pos_kp, pos_ki, pos_kd;
   logic [LIMIT_W-1:0]          pwm_limit;

   logic [TICK_CNT_W-1:0]       ticks;
   logic                        follow_mode;
   logic signed [DELTA_W-1:0]   speed_target;
   logic [ERR_W-1:0]            enc_pos [2];
   logic signed [SPD_ERR_W-1:0] spd_err [3];
   logic signed [ACC_W-1:0]     spd_acc;
   // Loop 1 history first, then loop 2; newest entry first in each.
   logic signed [ERR_W-1:0]     pos_err [6];
   logic signed [ACC_W-1:0]     pos_acc [2];

   rsp_word_type pwm_expected [$];
   int fails = 0;

   task automatic restore_defaults();
      spd_kp       = RST_SPEED_KP;
      spd_ki       = RST_SPEED_KI;
      spd_kd       = RST_SPEED_KD;
      pos_kp       = RST_POS_KP;
      pos_ki       = RST_POS_KI;
      pos_kd       = RST_POS_KD;
      pwm_limit    = RST_OUT_LIMIT;
      ticks        = '0;
      follow_mode  = 1'b0;
      speed_target = '0;
      enc_pos[0]   = '0;
      enc_pos[1]   = '0;
      foreach (spd_err[i]) spd_err[i] = '0;
      foreach (pos_err[i]) pos_err[i] = '0;
      spd_acc      = '0;
      pos_acc[0]   = '0;
      pos_acc[1]   = '0;
      pwm_expected.delete();
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SPEED_KP:  spd_kp = data;
         CSR_SPEED_KI:  spd_ki = data;
         CSR_SPEED_KD:  spd_kd = data;
         CSR_POS_KP:    pos_kp = data;
         CSR_POS_KI:    pos_ki = data;
         CSR_POS_KD:    pos_kd = data;
         CSR_OUT_LIMIT: pwm_limit = data[LIMIT_W-1:0];
         default:       ;
      endcase
   endtask

   // Adds one incremental PID term to an output accumulator and clamps it to the
   // symmetric limit; the clamped value is what the loop keeps.
   function automatic longint next_output_acc(input logic [GAIN_W-1:0] kp, ki, kd,
                                              input longint e0, e1, e2, prior);
      longint gp, gi, gd, total, ceiling;
      gp      = kp;
      gi      = ki;
      gd      = kd;
      total   = prior + gp * (e0 - e1) + gi * e0 + gd * (e0 - 2 * e1 + e2);
      ceiling = longint'(pwm_limit) <<< GAIN_FRAC_BITS;
      if (total > ceiling) total = ceiling;
      if (total < -ceiling) total = -ceiling;
      return total;
   endfunction

   // Drive level is the accumulator truncated toward zero.
   function automatic logic signed [PWM_W-1:0] drive_level(input longint acc);
      if (acc < 0) return PWM_W'(-((-acc) >>> GAIN_FRAC_BITS));
      return PWM_W'(acc >>> GAIN_FRAC_BITS);
   endfunction

   task automatic advance_controller(input logic [OPCODE_W-1:0] op,
                                     input logic signed [DELTA_W-1:0] d1, d2, tgt);
      rsp_word_type word;
      case (op)
         OP_TOGGLE: begin
            follow_mode = ~follow_mode;
            if (follow_mode) begin
               foreach (pos_err[i]) pos_err[i] = '0;
               pos_acc[0] = '0;
               pos_acc[1] = '0;
            end else begin
               foreach (spd_err[i]) spd_err[i] = '0;
               spd_acc = '0;
            end
         end
         OP_SET_TARGET: speed_target = tgt;
         OP_TICK: begin
            ticks = ticks + 1'b1;
            if (ticks >= TICK_DIVIDE) begin
               ticks      = '0;
               enc_pos[0] = enc_pos[0] + ERR_W'(d1);
               enc_pos[1] = enc_pos[1] + ERR_W'(d2);
               if (follow_mode) begin
                  pos_err[2] = pos_err[1];
                  pos_err[1] = pos_err[0];
                  pos_err[0] = '0;
                  pos_acc[0] = next_output_acc(pos_kp, pos_ki, pos_kd, pos_err[0],
                                               pos_err[1], pos_err[2], pos_acc[0]);
                  pos_err[5] = pos_err[4];
                  pos_err[4] = pos_err[3];
                  pos_err[3] = signed'(enc_pos[0] - enc_pos[1]);
                  pos_acc[1] = next_output_acc(pos_kp, pos_ki, pos_kd, pos_err[3],
                                               pos_err[4], pos_err[5], pos_acc[1]);
                  word.pwm1 = drive_level(pos_acc[0]);
                  word.pwm2 = drive_level(pos_acc[1]);
               end else begin
                  spd_err[2] = spd_err[1];
                  spd_err[1] = spd_err[0];
                  spd_err[0] = speed_target - d1;
                  spd_acc    = next_output_acc(spd_kp, spd_ki, spd_kd, spd_err[0],
                                               spd_err[1], spd_err[2], spd_acc);
                  word.pwm1  = drive_level(spd_acc);
                  word.pwm2  = word.pwm1;
               end
               word.position_mode = follow_mode;
               pwm_expected.push_back(word);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input int want, input int got);
      fails++;
      if (fails <= REPORT_CAP)
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         restore_defaults();
      end else begin
         if (csr_we) write_register(csr_index, csr_wdata);
         if (req_bus.valid && req_bus.ready)
            advance_controller(req_bus.opcode, req_bus.enc1_delta, req_bus.enc2_delta,
                               req_bus.target_speed);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pwm_expected.size() == 0) begin
               fails++;
               if (fails <= REPORT_CAP)
                  $display("%0t: result pwm1 %0d pwm2 %0d mode %0d with none expected",
                           $time, rsp_bus.pwm1, rsp_bus.pwm2, rsp_bus.position_mode);
            end else begin
               want = pwm_expected.pop_front();
               if (rsp_bus.pwm1 !== want.pwm1) report("pwm1", want.pwm1, rsp_bus.pwm1);
               if (rsp_bus.pwm2 !== want.pwm2) report("pwm2", want.pwm2, rsp_bus.pwm2);
               if (rsp_bus.position_mode !== want.position_mode)
                  report("position_mode", want.position_mode, rsp_bus.position_mode);
            end
         end
      end
      results_due <= pwm_expected.size();
      error_count <= fails;
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the dual motor PID unit: clock, reset, request and
// register stimulus, a stalling result consumer and the verdict.
// Depends on dmip_pkg, dmip_ifs, the unit itself and pid_step_checker.
module tb;
   import dmip_pkg::*;

   localparam int TICK_DIVIDE    = 10;
   localparam int GAIN_FRAC_BITS = 12;
   // The unit is seven stages deep; this covers words that make no result.
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASES         = 6;
   localparam int PHASE_WORDS    = 150;
   localparam int BACKLOG_HOLD   = 400;
   // Ticks of the closing position mode run at full opposite deltas.
   localparam int DRIFT_WORDS    = 180;
   localparam int CYCLE_LIMIT    = 2_000_000;

   localparam logic [OPCODE_W-1:0]  OP_UNUSED    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    error_count;
   int                    results_due;

   // Stimulus-to-consumer controls. A change of backlog_asks asks the consumer
   // for one long hold-off; sink_open takes away all its other stalls.
   int backlog_asks = 0;
   bit sink_open    = 1'b0;
   // Mode the unit is in, tracked from the toggle words that were sent.
   bit follow_now   = 1'b0;

   dmip_req_if req_bus();
   dmip_rsp_if rsp_bus();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dual_motor_incremental_pid_unit #(
      .TICK_DIVIDE   (TICK_DIVIDE),
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pid_step_checker #(
      .TICK_DIVIDE   (TICK_DIVIDE),
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) step_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .error_count(error_count),
      .results_due(results_due)
   );

   // Field values: mostly small, so that loops stay out of the clamp, with the
   // extremes and fully random words mixed in so every bit toggles.
   function automatic logic signed [DELTA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return DELTA_W'($urandom);
         default: return DELTA_W'($urandom_range(0, 400)) - 16'sd200;
      endcase
   endfunction

   // Presents one word and returns at the edge that accepts it. Valid stays
   // high afterwards, so back-to-back words never lower it.
   task automatic offer(input logic [OPCODE_W-1:0] op,
                        input logic signed [DELTA_W-1:0] d1, d2, tgt);
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.enc1_delta   <= d1;
      req_bus.enc2_delta   <= d2;
      req_bus.target_speed <= tgt;
      if (op == OP_TOGGLE) follow_now = ~follow_now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic sender_gap(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted result word has arrived.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Register writes happen only with the unit empty: drained, and then long
   // enough for ticks and toggles that make no result to leave the pipeline.
   task automatic settle_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write enable stays high across consecutive writes; the caller lowers it.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_gains(input logic [GAIN_W-1:0] skp, ski, skd, pkp, pki, pkd,
                             input logic [LIMIT_W-1:0] lim);
      write_csr(CSR_SPEED_KP, skp);
      write_csr(CSR_SPEED_KI, ski);
      write_csr(CSR_SPEED_KD, skd);
      write_csr(CSR_POS_KP, pkp);
      write_csr(CSR_POS_KI, pki);
      write_csr(CSR_POS_KD, pkd);
      // The upper byte of the limit write is random; the unit keeps only eight bits.
      write_csr(CSR_OUT_LIMIT, {8'($urandom), lim});
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input int phase);
      case (phase)
         1: load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
         2: load_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
         3: load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 8'($urandom));
         4: begin
            // A write to an index past the register list must change nothing.
            write_csr(CSR_UNMAPPED, 16'($urandom));
            load_gains(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                       16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                       16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                       8'($urandom_range(1, 255)));
         end
         default: load_gains(RST_SPEED_KP, RST_SPEED_KI, RST_SPEED_KD, RST_POS_KP,
                             RST_POS_KI, RST_POS_KD, RST_OUT_LIMIT);
      endcase
   endtask

   // One phase of random words. Ticks dominate so that control steps come
   // often; target changes and mode toggles land between them at random, and
   // the unused opcode shows up now and then without counting as a word.
   // A steady phase never pauses, so the consumer's long hold-off fills the unit.
   task automatic random_phase(input int words, input bit steady);
      int sent, burst, roll;
      bit drained;
      logic [OPCODE_W-1:0] op;
      sent    = 0;
      burst   = 0;
      drained = 1'b0;
      while (sent < words) begin
         if (!steady && !drained && sent >= words / 2) begin
            wait_drained();
            drained = 1'b1;
         end
         if (!steady && burst == 0) begin
            burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
            sender_gap($urandom_range(1, 15));
         end
         if (burst > 0) burst--;
         roll = $urandom_range(0, 99);
         if (roll < 84)      op = OP_TICK;
         else if (roll < 92) op = OP_SET_TARGET;
         else if (roll < 97) op = OP_TOGGLE;
         else                op = OP_UNUSED;
         offer(op, pick_value(), pick_value(), pick_value());
         if (op != OP_UNUSED) sent++;
      end
   endtask

   // Result consumer. It picks a stall style for a random stretch of cycles:
   // always ready, half the time, a quarter of the time, or stalled throughout.
   // A backlog request from the stimulus forces one long hold-off.
   initial begin : consumer
      int served, hold, stretch, style;
      served  = 0;
      hold    = 0;
      stretch = 0;
      style   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (served != backlog_asks) begin
            served = backlog_asks;
            hold   = BACKLOG_HOLD;
         end
         if (stretch == 0) begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(8, 80);
         end
         stretch--;
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_open) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            case (style)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= 1'b0;
            endcase
         end
      end
   end

   // Watchdog: a correct run ends long before this.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: cycle limit reached");
      $display("tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_TICK;
      req_bus.enc1_delta   <= '0;
      req_bus.enc2_delta   <= '0;
      req_bus.target_speed <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset gains: setpoint extremes, the unused
      // opcode, and a control step in each mode whose dividing tick carries
      // the extreme deltas. Ticks that do not divide leave positions alone.
      offer(OP_SET_TARGET, '0, '0, 16'sh7FFF);
      offer(OP_SET_TARGET, '0, '0, 16'sh8000);
      offer(OP_UNUSED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      offer(OP_SET_TARGET, '0, '0, 16'sd100);
      for (int i = 0; i < TICK_DIVIDE - 1; i++)
         offer(OP_TICK, pick_value(), pick_value(), pick_value());
      offer(OP_TICK, 16'sh7FFF, 16'sh8000, '0);
      offer(OP_TOGGLE, '0, '0, '0);
      for (int i = 0; i < TICK_DIVIDE - 1; i++)
         offer(OP_TICK, pick_value(), pick_value(), pick_value());
      offer(OP_TICK, 16'sh8000, 16'sh7FFF, '0);
      offer(OP_TOGGLE, '0, '0, '0);

      // Random phases, each under its own register setting: reset values,
      // everything at maximum, everything at zero, random, small gains, and the
      // reset values written back. The random phase runs with a backlog.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle_idle();
            apply_setting(phase);
         end
         if (phase == 3) backlog_asks <= backlog_asks + 1;
         random_phase(PHASE_WORDS, phase == 3);
      end

      // Closing run in position mode with opposite full-scale deltas, so the
      // position difference grows steadily and drives the follow loop hard.
      settle_idle();
      sink_open <= 1'b1;
      if (!follow_now) offer(OP_TOGGLE, '0, '0, '0);
      for (int i = 0; i < DRIFT_WORDS; i++)
         offer(OP_TICK, 16'sh7FFF, 16'sh8000, '0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && results_due == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
rtl/core/dmip_pkg.sv
rtl/core/dmip_ifs.sv
rtl/core/dmip_front.sv
rtl/core/dmip_lane.sv
rtl/core/dmip_merge.sv
rtl/core/dual_motor_incremental_pid_unit.sv
dv/pid_step_checker.sv
dv/tb.sv
